/* rtl/core/bol_pkg.sv */
// Package for the bounded ordered list: sizes, command and status codes,
// transaction payload types and the broadcast control word of the cell chain.
// No dependencies.
package bol_pkg;

    localparam int DEPTH      = 16;
    localparam int DATA_WIDTH = 32;
    localparam int IDX_W      = $clog2(DEPTH);
    localparam int CNT_W      = $clog2(DEPTH + 1);
    localparam int CAP_W      = 5;

    typedef logic [DATA_WIDTH-1:0] word_t;

    typedef enum logic [2:0] {
        CMD_INS_FRONT = 3'd0,
        CMD_INS_BACK  = 3'd1,
        CMD_INS_AT    = 3'd2,
        CMD_REM_FRONT = 3'd3,
        CMD_REM_BACK  = 3'd4,
        CMD_REM_VALUE = 3'd5,
        CMD_SEARCH    = 3'd6
    } cmd_e;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_FULL     = 3'd1,
        ST_EMPTY    = 3'd2,
        ST_NOTFOUND = 3'd3,
        ST_BADINDEX = 3'd4
    } status_e;

    typedef enum logic [1:0] {
        OP_HOLD  = 2'd0,
        OP_OPEN  = 2'd1,
        OP_CLOSE = 2'd2
    } cell_op_e;

    typedef struct packed {
        logic [2:0]         command;
        logic signed [31:0] value_in;
        logic [4:0]         index_in;
    } in_t;

    typedef struct packed {
        logic signed [31:0] value_out;
        logic [3:0]         position;
        logic [2:0]         status;
        logic [4:0]         count_now;
    } out_t;

    typedef struct packed {
        cell_op_e          op;
        logic [IDX_W-1:0]  pos;
        logic [CNT_W-1:0]  count;
        logic              cmp_en;
        word_t             cmp_word;
        word_t             ins_word;
    } cell_ctrl_t;

endpackage

/* rtl/core/bol_cell.sv */
// One cell of the list chain: holds one word, compares it with the search word
// and shifts towards either neighbour. Depends on bol_pkg.
module bol_cell import bol_pkg::*; (
    input  logic             aclk,
    input  logic [IDX_W-1:0] index,
    input  cell_ctrl_t       ctrl,
    input  word_t            word_left,
    input  word_t            word_right,
    output word_t            word,
    output logic             match
);

    word_t word_reg;
    word_t word_next;
    logic  match_reg;
    logic  match_next;
    logic  occupied;

    assign occupied = CNT_W'(index) < ctrl.count;

    always_comb begin
        word_next = word_reg;
        case (ctrl.op)
            OP_OPEN: begin
                if (index == ctrl.pos) begin
                    word_next = ctrl.ins_word;
                end else if (index > ctrl.pos) begin
                    word_next = word_left;
                end
            end
            OP_CLOSE: begin
                if (index >= ctrl.pos) begin
                    word_next = word_right;
                end
            end
            default: word_next = word_reg;
        endcase
        match_next = ctrl.cmp_en ? (occupied && (word_reg == ctrl.cmp_word)) : match_reg;
    end

    always_ff @(posedge aclk) begin
        word_reg  <= word_next;
        match_reg <= match_next;
    end

    assign word  = word_reg;
    assign match = match_reg;

endmodule

/* rtl/core/bounded_ordered_list.sv */
// Bounded ordered list of signed words built as a chain of bol_cell cells.
// The cells compare their words with the search word as a transaction is
// accepted; the first-match pick and shift follow in the execute state, which
// waits while an earlier result is stalled. A new transaction is taken only in idle.
// Reset (aresetn low, synchronous): list empty, capacity 16, no result held.
// Depends on bol_pkg and bol_cell.
module bounded_ordered_list import bol_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_we,
    input  logic [CAP_W-1:0] cfg_wdata,
    input  logic             s_valid,
    output logic             s_ready,
    input  in_t              s_data,
    output logic             m_valid,
    input  logic             m_ready,
    output out_t             m_data
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } state_e;

    state_e           state_reg, state_next;
    logic [CAP_W-1:0] cap_reg;
    logic [CNT_W-1:0] count_reg, count_next;
    in_t              cmd_reg;
    logic             m_valid_reg, m_valid_next;
    out_t             m_data_reg, m_data_next;

    word_t            words [DEPTH];
    logic [DEPTH-1:0] match;
    logic [DEPTH-1:0] first_hot;
    cell_ctrl_t       ctrl;

    logic             accept;
    logic             done;
    logic [CNT_W-1:0] limit;
    logic             full;
    logic             empty;
    logic             found;
    logic [IDX_W-1:0] match_pos;
    logic [IDX_W-1:0] back_idx;
    cell_op_e         op;
    logic [IDX_W-1:0] at;
    status_e          status;
    word_t            removed;
    logic [IDX_W-1:0] pos_out;
    logic [CNT_W-1:0] cnt_res;

    assign s_ready = (state_reg == S_IDLE);
    assign accept  = s_valid && s_ready;
    assign done    = (state_reg == S_EXEC) && (!m_valid_reg || m_ready);

    assign limit = ((cap_reg == '0) || (32'(cap_reg) > DEPTH)) ? CNT_W'(DEPTH)
                                                               : CNT_W'(cap_reg);
    assign full  = count_reg >= limit;
    assign empty = (count_reg == '0);

    assign first_hot = match & (~match + DEPTH'(1));
    assign found     = |match;
    assign back_idx  = IDX_W'(count_reg - CNT_W'(1));

    always_comb begin
        match_pos = '0;
        for (int k = 0; k < DEPTH; k++) begin
            if (first_hot[k]) begin
                match_pos = match_pos | IDX_W'(k);
            end
        end
    end

    always_comb begin
        op      = OP_HOLD;
        at      = '0;
        status  = ST_OK;
        removed = '0;
        pos_out = '0;
        cnt_res = count_reg;
        unique case (cmd_reg.command) inside
            CMD_INS_FRONT, CMD_INS_BACK, CMD_INS_AT: begin
                if (full) begin
                    status = ST_FULL;
                end else if (cmd_reg.command == CMD_INS_AT
                             && CNT_W'(cmd_reg.index_in) > count_reg) begin
                    status = ST_BADINDEX;
                end else begin
                    op      = OP_OPEN;
                    at      = (cmd_reg.command == CMD_INS_FRONT) ? '0
                            : (cmd_reg.command == CMD_INS_BACK)  ? IDX_W'(count_reg)
                            : IDX_W'(cmd_reg.index_in);
                    cnt_res = count_reg + CNT_W'(1);
                end
            end
            CMD_REM_FRONT: begin
                if (empty) begin
                    status = ST_EMPTY;
                end else begin
                    removed = words[0];
                    op      = OP_CLOSE;
                    cnt_res = count_reg - CNT_W'(1);
                end
            end
            CMD_REM_BACK: begin
                if (empty) begin
                    status = ST_EMPTY;
                end else begin
                    removed = words[back_idx];
                    cnt_res = count_reg - CNT_W'(1);
                end
            end
            CMD_REM_VALUE, CMD_SEARCH: begin
                if (empty) begin
                    status = ST_EMPTY;
                end else if (!found) begin
                    status = ST_NOTFOUND;
                end else begin
                    pos_out = match_pos;
                    if (cmd_reg.command == CMD_REM_VALUE) begin
                        op      = OP_CLOSE;
                        at      = match_pos;
                        cnt_res = count_reg - CNT_W'(1);
                    end
                end
            end
            default: ;
        endcase
    end

    always_comb begin
        ctrl.op       = done ? op : OP_HOLD;
        ctrl.pos      = at;
        ctrl.count    = count_reg;
        ctrl.cmp_en   = accept;
        ctrl.cmp_word = DATA_WIDTH'(s_data.value_in);
        ctrl.ins_word = DATA_WIDTH'(cmd_reg.value_in);
    end

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        bol_cell u_cell (
            .aclk       (aclk),
            .index      (IDX_W'(g)),
            .ctrl       (ctrl),
            .word_left  (words[(g == 0) ? 0 : g - 1]),
            .word_right (words[(g == DEPTH - 1) ? g : g + 1]),
            .word       (words[g]),
            .match      (match[g])
        );
    end

    always_comb begin
        state_next   = state_reg;
        count_next   = count_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                if (done) begin
                    state_next            = S_IDLE;
                    count_next            = cnt_res;
                    m_valid_next          = 1'b1;
                    m_data_next.value_out = 32'(removed);
                    m_data_next.position  = 4'(pos_out);
                    m_data_next.status    = status;
                    m_data_next.count_now = 5'(cnt_res);
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            cap_reg     <= CAP_W'(DEPTH);
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
            if (cfg_we) begin
                cap_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
        if (accept) begin
            cmd_reg <= s_data;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

/* rtl/core/bol_checker.sv */
// Port-level checks for bounded_ordered_list, bound to the top level.
// Depends on bol_pkg and bounded_ordered_list.
module bol_checker import bol_pkg::*; (
    input logic             aclk,
    input logic             aresetn,
    input logic             m_valid,
    input logic             m_ready,
    input out_t             m_data
);

    a_result_held: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result transaction dropped or changed while stalled");

    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.status <= ST_BADINDEX && 32'(m_data.count_now) <= DEPTH)
        else $error("status or count out of range");

    a_empty_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status == ST_EMPTY |-> m_data.count_now == '0)
        else $error("empty status with elements held");

    a_removed_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.value_out != '0 || m_data.position != '0)
            |-> m_data.status == ST_OK)
        else $error("removed word or position given on a failed transaction");

endmodule

bind bounded_ordered_list bol_checker u_bol_checker (.*);

/* verif/tb_bounded_ordered_list.sv */
// Self-checking testbench for bounded_ordered_list: directed and random list
// commands over valid/ready, predicted by a shadow list and checked in order.
// Depends on bol_pkg and the bounded_ordered_list RTL.
module tb_bounded_ordered_list;
    timeunit 1ns;
    timeprecision 1ps;
    import bol_pkg::*;

    localparam logic [2:0] CMD_UNUSED  = 3'd7;
    localparam int         CYCLE_LIMIT = 400000;
    localparam int         MAX_REPORTS = 10;

    logic             aclk;
    logic             aresetn   = 1'b0;
    logic             cfg_we    = 1'b0;
    logic [CAP_W-1:0] cfg_wdata = '0;
    logic             s_valid   = 1'b0;
    logic             s_ready;
    in_t              s_data    = '0;
    logic             m_valid;
    logic             m_ready   = 1'b0;
    out_t             m_data;

    // shadow copy of the list
    word_t      shadow_words [DEPTH];
    int         shadow_count    = 0;
    logic [4:0] shadow_capacity = 5'd16;

    out_t expected_results [$];
    int   gap_pct         = 0;
    int   stall_pct       = 0;
    int   failures        = 0;
    int   commands_sent   = 0;
    int   results_checked = 0;
    int   cycle_count     = 0;
    int   status_seen [5] = '{0, 0, 0, 0, 0};

    bounded_ordered_list DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, expected_results.size());
            $display("CHECK FAILED");
            $finish;
        end
    end

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    function automatic void log_failure(string msg);
        failures++;
        if (failures <= MAX_REPORTS)
            $display("%s", msg);
    endfunction

    function automatic out_t predict_list_result(in_t t);
        out_t r;
        int   limit;
        int   at;
        int   hit;
        bit   full;
        r     = '0;
        limit = (shadow_capacity == 0 || shadow_capacity > DEPTH) ? DEPTH : shadow_capacity;
        full  = (shadow_count >= limit);
        hit   = -1;
        case (t.command)
            CMD_INS_FRONT, CMD_INS_BACK, CMD_INS_AT: begin
                at = (t.command == CMD_INS_FRONT) ? 0 : shadow_count;
                if (t.command == CMD_INS_AT)
                    at = t.index_in;
                if (full) begin
                    r.status = ST_FULL;
                end else if (at > shadow_count) begin
                    r.status = ST_BADINDEX;
                end else begin
                    for (int k = shadow_count; k > at; k--)
                        shadow_words[k] = shadow_words[k-1];
                    shadow_words[at] = t.value_in;
                    shadow_count++;
                end
            end
            CMD_REM_FRONT: begin
                if (shadow_count == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    r.value_out = shadow_words[0];
                    for (int k = 0; k + 1 < shadow_count; k++)
                        shadow_words[k] = shadow_words[k+1];
                    shadow_count--;
                end
            end
            CMD_REM_BACK: begin
                if (shadow_count == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    r.value_out = shadow_words[shadow_count-1];
                    shadow_count--;
                end
            end
            CMD_REM_VALUE, CMD_SEARCH: begin
                if (shadow_count == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    for (int k = 0; k < shadow_count; k++)
                        if (hit < 0 && shadow_words[k] == t.value_in)
                            hit = k;
                    if (hit < 0) begin
                        r.status = ST_NOTFOUND;
                    end else begin
                        r.position = 4'(hit);
                        if (t.command == CMD_REM_VALUE) begin
                            for (int k = hit; k + 1 < shadow_count; k++)
                                shadow_words[k] = shadow_words[k+1];
                            shadow_count--;
                        end
                    end
                end
            end
            default: ;
        endcase
        r.count_now = 5'(shadow_count);
        return r;
    endfunction

    // one transaction in, prediction made at the accepting edge
    task automatic send_command(input logic [2:0] op, input word_t value,
                                input logic [4:0] index);
        in_t  item;
        out_t want;
        int   idle;
        item.command  = op;
        item.value_in = value;
        item.index_in = index;
        idle = 0;
        while ($urandom_range(0, 99) < gap_pct)
            idle++;
        if (idle > 0) begin
            s_valid <= 1'b0;
            repeat (idle) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= item;
        do @(posedge aclk); while (!(s_valid && s_ready));
        want = predict_list_result(item);
        expected_results.push_back(want);
        status_seen[want.status]++;
        commands_sent++;
    endtask

    task automatic wait_list_idle();
        s_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge aclk);
        repeat (3) @(posedge aclk);
    endtask

    task automatic write_capacity(input logic [4:0] cap);
        wait_list_idle();
        cfg_we          <= 1'b1;
        cfg_wdata       <= cap;
        shadow_capacity  = cap;
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    always @(posedge aclk) begin : check_results
        out_t want;
        if (aresetn && m_valid && m_ready) begin
            results_checked++;
            if (expected_results.size() == 0) begin
                log_failure($sformatf(
                    "unexpected result: value %h pos %0d status %0d count %0d",
                    m_data.value_out, m_data.position, m_data.status,
                    m_data.count_now));
            end else begin
                want = expected_results.pop_front();
                if (m_data.value_out !== want.value_out || m_data.position !== want.position ||
                    m_data.status !== want.status || m_data.count_now !== want.count_now)
                    log_failure($sformatf({
                        "result %0d mismatch: exp value %h pos %0d status %0d count %0d, ",
                        "got value %h pos %0d status %0d count %0d"},
                        results_checked, want.value_out, want.position, want.status,
                        want.count_now, m_data.value_out, m_data.position, m_data.status,
                        m_data.count_now));
            end
        end
    end

    task automatic test_empty_list();
        send_command(CMD_REM_FRONT, 32'h0000_0001, 5'd0);
        send_command(CMD_REM_BACK,  32'hFFFF_FFFF, 5'd31);
        send_command(CMD_REM_VALUE, 32'h0000_0000, 5'd0);
        send_command(CMD_SEARCH,    32'h8000_0000, 5'd16);
        send_command(CMD_UNUSED,    32'h7FFF_FFFF, 5'd0);
    endtask

    task automatic test_insert_positions();
        send_command(CMD_INS_AT,    32'h0000_0011, 5'd1);
        send_command(CMD_INS_FRONT, 32'h8000_0000, 5'd0);
        send_command(CMD_INS_BACK,  32'h7FFF_FFFF, 5'd0);
        send_command(CMD_INS_AT,    32'hFFFF_FFFF, 5'd1);
        send_command(CMD_INS_AT,    32'h0000_0000, 5'd3);
        send_command(CMD_INS_AT,    32'h0000_0022, 5'd31);
        send_command(CMD_SEARCH,    32'hFFFF_FFFF, 5'd0);
        send_command(CMD_SEARCH,    32'h0000_3039, 5'd0);
        send_command(CMD_REM_VALUE, 32'h7FFF_FFFF, 5'd0);
        send_command(CMD_REM_FRONT, 32'h0000_0000, 5'd0);
        send_command(CMD_REM_BACK,  32'h0000_0000, 5'd0);
    endtask

    task automatic test_capacity_edges();
        write_capacity(5'd1);
        send_command(CMD_INS_BACK,  32'h0000_0005, 5'd0);
        send_command(CMD_INS_FRONT, 32'h0000_0006, 5'd0);
        // full takes precedence over a bad index
        send_command(CMD_INS_AT,    32'h0000_0007, 5'd9);
        write_capacity(5'd16);
        send_command(CMD_INS_BACK,  32'h0000_0008, 5'd0);
        // limit now below the count
        write_capacity(5'd1);
        send_command(CMD_INS_BACK,  32'h0000_0009, 5'd0);
        send_command(CMD_REM_FRONT, 32'h0000_0000, 5'd0);
        send_command(CMD_REM_BACK,  32'h0000_0000, 5'd0);
        write_capacity(5'd0);
        send_command(CMD_INS_FRONT, 32'h0000_000A, 5'd0);
        send_command(CMD_REM_BACK,  32'h0000_0000, 5'd0);
    endtask

    task automatic test_random_mix();
        logic [4:0] caps [8];
        logic [2:0] op;
        word_t      value;
        logic [4:0] index;
        int         roll;
        int         bias;
        caps = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd17, 5'd3, 5'd16, 5'd16};
        caps[7] = 5'($urandom_range(1, 16));
        for (int p = 0; p < 8; p++) begin
            write_capacity(caps[p]);
            case (p % 4)
                0: begin gap_pct = 0;  stall_pct = 0;  end
                1: begin gap_pct = 80; stall_pct = 0;  end
                2: begin gap_pct = 0;  stall_pct = 80; end
                default: begin gap_pct = 29; stall_pct = 29; end
            endcase
            for (int n = 0; n < 130; n++) begin
                // alternate fill and drain bursts so full and empty both come up
                bias = ((n / 24) % 2 == 0) ? 75 : 30;
                roll = $urandom_range(0, 99);
                if (roll < 2)
                    op = CMD_UNUSED;
                else if (roll < 2 + bias)
                    op = 3'($urandom_range(CMD_INS_FRONT, CMD_INS_AT));
                else
                    op = 3'($urandom_range(CMD_REM_FRONT, CMD_SEARCH));
                roll = $urandom_range(0, 99);
                if (roll < 50 && shadow_count > 0) begin
                    value = shadow_words[$urandom_range(0, shadow_count - 1)];
                end else if (roll < 65) begin
                    case ($urandom_range(0, 3))
                        0: value = 32'h8000_0000;
                        1: value = 32'h7FFF_FFFF;
                        2: value = 32'hFFFF_FFFF;
                        default: value = 32'h0000_0000;
                    endcase
                end else begin
                    value = $urandom();
                end
                roll = $urandom_range(0, 99);
                if (roll < 70)
                    index = 5'($urandom_range(0, shadow_count));
                else if (roll < 90)
                    index = 5'($urandom_range(0, 16));
                else
                    index = 5'($urandom_range(0, 31));
                send_command(op, value, index);
            end
        end
        gap_pct   = 0;
        stall_pct = 0;
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_empty_list();
        test_insert_positions();
        test_capacity_edges();
        test_random_mix();
        wait_list_idle();
        if (expected_results.size() != 0)
            log_failure($sformatf("%0d results never arrived", expected_results.size()));
        $display("%0d commands, %0d results checked, capacities 0 to 31 applied",
                 commands_sent, results_checked);
        $display("status counts ok/full/empty/not found/bad index: %0d/%0d/%0d/%0d/%0d",
                 status_seen[0], status_seen[1], status_seen[2], status_seen[3],
                 status_seen[4]);
        if (failures == 0) begin
            $display("CHECK OK");
        end else begin
            $display("%0d failures", failures);
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

/* bounded_ordered_list.f */
rtl/core/bol_pkg.sv
rtl/core/bol_cell.sv
rtl/core/bounded_ordered_list.sv
rtl/core/bol_checker.sv
verif/tb_bounded_ordered_list.sv
